// ===== rtl/text_console_cursor_renderer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Text console cursor renderer: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_RENDERER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_RENDERER_TOP_DEFINES_SVH

// same-cycle implication
`define TCCR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCCR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tccr_pkg.sv =====
// ----------------------------------------------------------------------------
// tccr_pkg
// Constants, codes and shared types of the text console cursor renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package tccr_pkg;

   // cell geometry
   localparam int GLYPH_WIDTH   = 8;
   localparam int GLYPH_HEIGHT  = 11;
   localparam int LINE_GAP      = 2;
   localparam int MARGIN_PIXELS = 4;
   localparam int SCROLL_LINES  = 3;
   localparam int LINE_HEIGHT   = GLYPH_HEIGHT + LINE_GAP;

   // field widths
   localparam int CHAR_W   = 8;
   localparam int CODE_W   = 7;
   localparam int ROW_W    = 4;
   localparam int COLOR_W  = 24;
   localparam int OFFSET_W = 26;
   localparam int CURSOR_W = 12;
   localparam int POS_W    = 13;   // emitted cell position, may exceed cursor range
   localparam int SIZE_W   = 13;
   localparam int PITCH_W  = 15;
   localparam int PIXB_W   = 3;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_PITCH    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_BYTES   = 2'd3;

   localparam logic [SIZE_W-1:0]  RST_SCREEN_WIDTH  = 13'd1024;
   localparam logic [SIZE_W-1:0]  RST_SCREEN_HEIGHT = 13'd768;
   localparam logic [PITCH_W-1:0] RST_LINE_PITCH    = 15'd3072;
   localparam logic [PIXB_W-1:0]  RST_PIXEL_BYTES   = 3'd3;

   // character codes; the first printable is also the blank glyph
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE   = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE     = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_FIRST = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_LAST  = 8'd126;

   // result kinds
   localparam logic KIND_GLYPH_ROW = 1'b0;
   localparam logic KIND_SCROLL    = 1'b1;

   // command queue
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

   typedef struct packed {
      logic [SIZE_W-1:0]  screen_width;
      logic [SIZE_W-1:0]  screen_height;
      logic [PITCH_W-1:0] line_pitch;
      logic [PIXB_W-1:0]  pixel_bytes;
   } cfg_type;

   // one classified item: optional scroll before, optional glyph rows, optional scroll after
   typedef struct packed {
      logic                pre_scroll;
      logic                rows;
      logic                post_scroll;
      logic [CODE_W-1:0]   code;
      logic [COLOR_W-1:0]  color;
      logic [OFFSET_W-1:0] offset;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/tccr_front.sv =====
// ----------------------------------------------------------------------------
// tccr_front
// Accepts characters, moves the cursor, classifies each into a draw command.
// ----------------------------------------------------------------------------
`default_nettype none

module tccr_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tccr_pkg::cfg_type             cfg,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [tccr_pkg::CHAR_W-1:0]   req_char_code,
   input  wire logic [tccr_pkg::COLOR_W-1:0]  req_text_color,
   input  wire logic                          cmd_full,
   output logic                               cmd_push,
   output tccr_pkg::cmd_type                  cmd_data
);
   import tccr_pkg::*;

   localparam int SW = POS_W + 2;   // signed working width
   localparam logic signed [SW-1:0] GW_S = SW'(GLYPH_WIDTH);
   localparam logic signed [SW-1:0] MG_S = SW'(MARGIN_PIXELS);
   localparam logic signed [SW-1:0] LH_S = SW'(LINE_HEIGHT);
   localparam logic signed [SW-1:0] RIGHT_S = SW'(GLYPH_WIDTH + MARGIN_PIXELS);
   localparam logic signed [SW-1:0] BOTTOM_S = SW'(LINE_HEIGHT + MARGIN_PIXELS);
   localparam logic signed [SW-1:0] ROOM_S = SW'(2 * MARGIN_PIXELS + GLYPH_WIDTH);
   localparam logic signed [SW-1:0] SCROLL_S = SW'(MARGIN_PIXELS + SCROLL_LINES * LINE_HEIGHT);

   logic [CURSOR_W-1:0] col_ff, col_in, line_ff, line_in;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_pre_ff, s1_rows_ff, s1_post_ff;
   logic [CODE_W-1:0]   s1_code_ff;
   logic [COLOR_W-1:0]  s1_color_ff;
   logic [POS_W-1:0]    s1_x_ff, s1_y_ff;

   logic signed [SW-1:0] w_s, h_s, col_s, line_s;
   logic signed [SW-1:0] cx0, cy0, cx1, cy1, cx2, cy2, room, last_cell, scroll_y;
   logic                 is_bs, is_print, scroll, has_results, accept;
   logic [POS_W-1:0]     emit_x, emit_y;

   logic [PITCH_W+POS_W-1:0] prod_y;
   logic [PIXB_W+POS_W-1:0]  prod_x;

   // bound check on the moved cursor
   always_comb begin
      w_s    = signed'({2'b00, cfg.screen_width});
      h_s    = signed'({2'b00, cfg.screen_height});
      col_s  = signed'({3'b000, col_ff});
      line_s = signed'({3'b000, line_ff});
      is_bs    = 1'b0;
      unique case (req_char_code)
         CHAR_NEWLINE: begin
            cx0   = MG_S;
            cy0   = line_s + LH_S;
         end
         CHAR_BACKSPACE: begin
            is_bs = 1'b1;
            cx0   = col_s - GW_S;
            cy0   = line_s;
         end
         default: begin
            cx0 = col_s + GW_S;
            cy0 = line_s;
         end
      endcase
      is_print = (req_char_code >= CHAR_PRINT_FIRST) && (req_char_code <= CHAR_PRINT_LAST);

      room      = w_s - ROOM_S;
      last_cell = (room < 0) ? MG_S : MG_S + (room / GW_S) * GW_S;

      if (cx0 + RIGHT_S > w_s) begin
         cx1 = MG_S;
         cy1 = cy0 + LH_S;
      end else if (cx0 < MG_S) begin
         cx1 = last_cell;
         cy1 = cy0 - LH_S;
      end else begin
         cx1 = cx0;
         cy1 = cy0;
      end

      scroll_y = h_s - SCROLL_S;
      scroll   = (cy1 + BOTTOM_S > h_s);
      if (scroll) begin
         cx2 = MG_S;
         cy2 = (scroll_y < MG_S) ? MG_S : scroll_y;
      end else begin
         cx2 = cx1;
         cy2 = (cy1 < MG_S) ? MG_S : cy1;
      end

      // backspace draws at the checked position, printables at the old one
      emit_x = is_bs ? cx2[POS_W-1:0] : {1'b0, col_ff};
      emit_y = is_bs ? cy2[POS_W-1:0] : {1'b0, line_ff};
      has_results = scroll || is_bs || is_print;
   end

   assign cmd_push  = s1_valid_ff && !cmd_full;
   assign req_stall = s1_valid_ff && cmd_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      col_in      = col_ff;
      line_in     = line_ff;
      s1_valid_in = s1_valid_ff && !cmd_push;
      if (accept) begin
         col_in      = cx2[CURSOR_W-1:0];
         line_in     = cy2[CURSOR_W-1:0];
         s1_valid_in = has_results;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= CURSOR_W'(MARGIN_PIXELS);
         line_ff     <= CURSOR_W'(MARGIN_PIXELS);
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         line_ff     <= line_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pre_ff   <= is_bs && scroll;
         s1_rows_ff  <= is_bs || is_print;
         s1_post_ff  <= scroll && !is_bs;
         s1_code_ff  <= is_bs ? CHAR_PRINT_FIRST[CODE_W-1:0] : req_char_code[CODE_W-1:0];
         s1_color_ff <= is_bs ? '0 : req_text_color;
         s1_x_ff     <= emit_x;
         s1_y_ff     <= emit_y;
      end
   end

   // row-0 byte offset, registered in the queue
   assign prod_y = {{POS_W{1'b0}}, cfg.line_pitch} * {{PITCH_W{1'b0}}, s1_y_ff};
   assign prod_x = {{POS_W{1'b0}}, cfg.pixel_bytes} * {{PIXB_W{1'b0}}, s1_x_ff};

   always_comb begin
      cmd_data.pre_scroll  = s1_pre_ff;
      cmd_data.rows        = s1_rows_ff;
      cmd_data.post_scroll = s1_post_ff;
      cmd_data.code        = s1_code_ff;
      cmd_data.color       = s1_color_ff;
      cmd_data.offset      = prod_y[OFFSET_W-1:0]
                           + {{(OFFSET_W-PIXB_W-POS_W){1'b0}}, prod_x};
   end

endmodule

`default_nettype wire

// ===== rtl/tccr_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// tccr_cmd_fifo
// Short command queue between the classifier and the row sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tccr_cmd_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tccr_pkg::cmd_type push_data,
   input  wire logic              pop,
   output tccr_pkg::cmd_type      head,
   output logic                   full,
   output logic                   empty
);
   import tccr_pkg::*;

   cmd_type              entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CMD_PTR_W:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == (CMD_PTR_W+1)'(CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

// ===== rtl/tccr_back.sv =====
// ----------------------------------------------------------------------------
// tccr_back
// Row sequencer: turns one command into scroll and glyph-row results.
// ----------------------------------------------------------------------------
`default_nettype none

module tccr_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tccr_pkg::cfg_type              cfg,
   input  wire tccr_pkg::cmd_type              cmd_head,
   input  wire logic                           cmd_empty,
   output logic                                cmd_pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_kind,
   output logic [tccr_pkg::CODE_W-1:0]         rsp_glyph_code,
   output logic [tccr_pkg::ROW_W-1:0]          rsp_glyph_row,
   output logic [tccr_pkg::OFFSET_W-1:0]       rsp_pixel_offset,
   output logic [tccr_pkg::COLOR_W-1:0]        rsp_row_color,
   output logic                                rsp_last
);
   import tccr_pkg::*;

   logic                pre_ff, rows_ff, post_ff;
   logic                pre_in, rows_in, post_in;
   logic [ROW_W-1:0]    row_ff;
   logic [CODE_W-1:0]   code_ff;
   logic [COLOR_W-1:0]  color_ff;
   logic [OFFSET_W-1:0] offset_ff;

   logic                out_valid_ff, out_valid_in;
   logic                out_kind_ff, out_last_ff;
   logic [CODE_W-1:0]   out_code_ff;
   logic [ROW_W-1:0]    out_row_ff;
   logic [OFFSET_W-1:0] out_offset_ff;
   logic [COLOR_W-1:0]  out_color_ff;

   logic busy, out_free, fire, sel_pre, sel_row, sel_post, last_row, done;

   assign busy     = pre_ff || rows_ff || post_ff;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign fire     = busy && out_free;

   always_comb begin
      sel_pre  = pre_ff;
      sel_row  = !pre_ff && rows_ff;
      sel_post = !pre_ff && !rows_ff && post_ff;
      last_row = (row_ff == ROW_W'(GLYPH_HEIGHT - 1));
      pre_in   = pre_ff && !sel_pre;
      rows_in  = rows_ff && !(sel_row && last_row);
      post_in  = post_ff && !sel_post;
      done     = !(pre_in || rows_in || post_in);
   end

   assign cmd_pop      = !cmd_empty && (!busy || (fire && done));
   assign out_valid_in = out_free ? fire : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff       <= 1'b0;
         rows_ff      <= 1'b0;
         post_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd_pop) begin
            pre_ff  <= cmd_head.pre_scroll;
            rows_ff <= cmd_head.rows;
            post_ff <= cmd_head.post_scroll;
         end else if (fire) begin
            pre_ff  <= pre_in;
            rows_ff <= rows_in;
            post_ff <= post_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         row_ff    <= '0;
         code_ff   <= cmd_head.code;
         color_ff  <= cmd_head.color;
         offset_ff <= cmd_head.offset;
      end else if (fire && sel_row) begin
         row_ff    <= row_ff + 1'b1;
         offset_ff <= offset_ff + {{(OFFSET_W-PITCH_W){1'b0}}, cfg.line_pitch};
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_last_ff <= done;
         if (sel_row) begin
            out_kind_ff   <= KIND_GLYPH_ROW;
            out_code_ff   <= code_ff;
            out_row_ff    <= row_ff;
            out_offset_ff <= offset_ff;
            out_color_ff  <= color_ff;
         end else begin
            out_kind_ff   <= KIND_SCROLL;
            out_code_ff   <= '0;
            out_row_ff    <= '0;
            out_offset_ff <= '0;
            out_color_ff  <= '0;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_glyph_code   = out_code_ff;
   assign rsp_glyph_row    = out_row_ff;
   assign rsp_pixel_offset = out_offset_ff;
   assign rsp_row_color    = out_color_ff;
   assign rsp_last         = out_last_ff;

endmodule

`default_nettype wire

// ===== rtl/text_console_cursor_renderer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_renderer_top
// Text console cursor: characters in, glyph-row and scroll commands out.
// ----------------------------------------------------------------------------
//   channel | ports                          | direction | transfer when
//   --------+--------------------------------+-----------+-----------------------
//   req     | char_code, text_color          | in        | req_valid & !req_stall
//   rsp     | kind, glyph_code, glyph_row,   | out       | rsp_valid & !rsp_stall
//           | pixel_offset, row_color, last  |           |
//   csr     | index, wdata                   | in        | csr_we
//
// One result per cycle from the row sequencer unless rsp stalls: a printable or
// backspace gives a result per glyph row plus any scroll; a scrolling newline
// gives a scroll, others none. The front takes one character per cycle until
// the 4-entry command queue fills. A character passes the classifier register,
// queue, sequencer state and output register before rsp_valid rises.
// Reset (synchronous) restores register defaults, puts the cursor at the
// margin and empties the queue. A stall on rsp holds the output register and
// backs up through the queue; once the queue is full, req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_renderer_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [tccr_pkg::CHAR_W-1:0]        req_char_code,
   input  wire logic [tccr_pkg::COLOR_W-1:0]       req_text_color,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_kind,
   output logic [tccr_pkg::CODE_W-1:0]             rsp_glyph_code,
   output logic [tccr_pkg::ROW_W-1:0]              rsp_glyph_row,
   output logic [tccr_pkg::OFFSET_W-1:0]           rsp_pixel_offset,
   output logic [tccr_pkg::COLOR_W-1:0]            rsp_row_color,
   output logic                                    rsp_last,
   input  wire logic                               csr_we,
   input  wire logic [tccr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [tccr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tccr_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type push_data, head;
   logic    push, pop, full, empty;

   // register file; software must write it only while nothing is in flight; the block itself does not enforce this
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata[SIZE_W-1:0];
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata[SIZE_W-1:0];
            CSR_LINE_PITCH:    cfg_in.line_pitch    = csr_wdata[PITCH_W-1:0];
            CSR_PIXEL_BYTES:   cfg_in.pixel_bytes   = csr_wdata[PIXB_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= RST_SCREEN_HEIGHT;
         cfg_ff.line_pitch    <= RST_LINE_PITCH;
         cfg_ff.pixel_bytes   <= RST_PIXEL_BYTES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: cursor update, bound check, row-0 offset
   tccr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .req_text_color (req_text_color),
      .cmd_full       (full),
      .cmd_push       (push),
      .cmd_data       (push_data)
   );

   tccr_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   // back: one result per cycle into the output register while rsp is not stalled
   tccr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd_head         (head),
      .cmd_empty        (empty),
      .cmd_pop          (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_glyph_code   (rsp_glyph_code),
      .rsp_glyph_row    (rsp_glyph_row),
      .rsp_pixel_offset (rsp_pixel_offset),
      .rsp_row_color    (rsp_row_color),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/tccr_checker.sv =====
// ----------------------------------------------------------------------------
// tccr_checker
// Port-level checks on the renderer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_cursor_renderer_top_defines.svh"

module tccr_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic                               rsp_kind,
   input wire logic [tccr_pkg::CODE_W-1:0]        rsp_glyph_code,
   input wire logic [tccr_pkg::ROW_W-1:0]         rsp_glyph_row,
   input wire logic [tccr_pkg::OFFSET_W-1:0]      rsp_pixel_offset,
   input wire logic [tccr_pkg::COLOR_W-1:0]       rsp_row_color,
   input wire logic                               rsp_last
);
   import tccr_pkg::*;

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_HEIGHT - 1);

   `TCCR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")

   `TCCR_ASSERT_NOW(a_scroll_zero, clock, reset, rsp_valid && (rsp_kind == KIND_SCROLL), (rsp_glyph_code == '0) && (rsp_glyph_row == '0) && (rsp_pixel_offset == '0) && (rsp_row_color == '0), "scroll with nonzero payload")

   `TCCR_ASSERT_NOW(a_row_range, clock, reset, rsp_valid && (rsp_kind == KIND_GLYPH_ROW), (rsp_glyph_row <= LAST_ROW) && (rsp_last == 1'b0 || rsp_glyph_row == LAST_ROW), "glyph row out of range or early last")

   `TCCR_ASSERT_NEXT(a_row_seq, clock, reset, rsp_valid && !rsp_stall && (rsp_kind == KIND_GLYPH_ROW) && (rsp_glyph_row != LAST_ROW), rsp_valid && (rsp_kind == KIND_GLYPH_ROW) && (rsp_glyph_row == $past(rsp_glyph_row) + 1'b1), "glyph rows not contiguous")

endmodule

bind text_console_cursor_renderer_top tccr_checker u_checker (.*);

`default_nettype wire

// ===== tb/tb_text_console_cursor_renderer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_renderer_top
// Self-checking bench for the text console cursor renderer. A short script
// opens the run, then randomized phases over several screen geometries follow.
// Every glyph-row and scroll command is checked field by field against a
// cursor tracker kept inside the bench.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_renderer_top;
   import tccr_pkg::*;

   // one command as it leaves the rsp channel
   typedef struct packed {
      logic                kind;
      logic [CODE_W-1:0]   code;
      logic [ROW_W-1:0]    row;
      logic [OFFSET_W-1:0] offset;
      logic [COLOR_W-1:0]  color;
      logic                last;
   } console_cmd_type;

   typedef enum logic {STEP_CHAR, STEP_REG} step_kind_type;

   // scripted step: a character transfer or a register write. For a few
   // characters the first command is typed in by hand.
   typedef struct packed {
      step_kind_type           kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [CHAR_W-1:0]       code;
      logic [COLOR_W-1:0]      value;
      logic                    typed;
      console_cmd_type         first;
   } script_step_type;

   localparam console_cmd_type NO_CMD = '0;
   localparam int SCRIPT_LEN    = 26;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 20;
   localparam int TALL_PHASE    = 7;
   localparam int TALL_ITEMS    = 360;
   // covers the 4-deep command queue plus pipeline when no command is due
   localparam int SETTLE_CYCLES = 20;

   // ---------------------------------------------------------------- signals
   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [CHAR_W-1:0]      req_char_code  = '0;
   logic [COLOR_W-1:0]     req_text_color = '0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic                   rsp_kind;
   logic [CODE_W-1:0]      rsp_glyph_code;
   logic [ROW_W-1:0]       rsp_glyph_row;
   logic [OFFSET_W-1:0]    rsp_pixel_offset;
   logic [COLOR_W-1:0]     rsp_row_color;
   logic                   rsp_last;
   logic                   csr_we         = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata      = '0;

   // hand-typed first command travels alongside the char it belongs to
   logic                   drv_typed      = 1'b0;
   console_cmd_type        drv_first      = '0;

   text_console_cursor_renderer_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_text_color   (req_text_color),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_glyph_code   (rsp_glyph_code),
      .rsp_glyph_row    (rsp_glyph_row),
      .rsp_pixel_offset (rsp_pixel_offset),
      .rsp_row_color    (rsp_row_color),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------- cursor tracker
   // Shadow registers and cursor, updated at the same edges the block sees.
   logic [SIZE_W-1:0]   scr_w;
   logic [SIZE_W-1:0]   scr_h;
   logic [PITCH_W-1:0]  pitch_b;
   logic [PIXB_W-1:0]   pix_b;
   logic [CURSOR_W-1:0] cur_x;
   logic [CURSOR_W-1:0] cur_y;

   console_cmd_type pending_cmds[$];
   int              fail_count = 0;

   // rightmost cell that still fits inside the right margin
   function automatic int last_cell_x(input int w);
      int room;
      room = w - 2 * MARGIN_PIXELS - GLYPH_WIDTH;
      if (room < 0) return MARGIN_PIXELS;
      return MARGIN_PIXELS + (room / GLYPH_WIDTH) * GLYPH_WIDTH;
   endfunction

   // Wrap / unwrap horizontally, then clamp vertically. Returns 1 when the
   // screen has to scroll; the cursor then lands SCROLL_LINES above the bottom
   // (never above the top margin on a tiny screen).
   function automatic bit keep_on_screen(inout int x, inout int y);
      int w;
      int h;
      bit scrolled;
      w = int'(scr_w);
      h = int'(scr_h);
      scrolled = 1'b0;
      if (x + GLYPH_WIDTH + MARGIN_PIXELS > w) begin
         y += LINE_HEIGHT;
         x = MARGIN_PIXELS;
      end else if (x < MARGIN_PIXELS) begin
         x = last_cell_x(w);
         y -= LINE_HEIGHT;
      end
      if (y + LINE_HEIGHT + MARGIN_PIXELS > h) begin
         scrolled = 1'b1;
         x = MARGIN_PIXELS;
         y = h - MARGIN_PIXELS - SCROLL_LINES * LINE_HEIGHT;
         if (y < MARGIN_PIXELS) y = MARGIN_PIXELS;
      end else if (y < MARGIN_PIXELS) begin
         y = MARGIN_PIXELS;
      end
      return scrolled;
   endfunction

   function automatic void push_scroll();
      console_cmd_type c;
      c = '0;
      c.kind = KIND_SCROLL;
      pending_cmds.push_back(c);
   endfunction

   // offset = (y + row) * pitch + x * bytes, wrapped to the 26-bit field
   function automatic void push_rows(input logic [CODE_W-1:0] code, input int x,
                                     input int y, input logic [COLOR_W-1:0] color);
      console_cmd_type c;
      longint off;
      for (int j = 0; j < GLYPH_HEIGHT; j++) begin
         off = longint'(y + j) * longint'(pitch_b) + longint'(x) * longint'(pix_b);
         c = '{KIND_GLYPH_ROW, code, ROW_W'(j), off[OFFSET_W-1:0], color, 1'b0};
         pending_cmds.push_back(c);
      end
   endfunction

   // Commands caused by one character, appended in output order.
   function automatic void render_char(input logic [CHAR_W-1:0] ch,
                                       input logic [COLOR_W-1:0] color);
      int x;
      int y;
      int n0;
      console_cmd_type c;
      n0 = pending_cmds.size();
      x = int'(cur_x);
      y = int'(cur_y);
      if (ch == CHAR_NEWLINE) begin
         y += LINE_HEIGHT;
         x = MARGIN_PIXELS;
         if (keep_on_screen(x, y)) push_scroll();
      end else if (ch == CHAR_BACKSPACE) begin
         // bound check first: a scroll goes ahead of the black blank cell
         x -= GLYPH_WIDTH;
         if (keep_on_screen(x, y)) push_scroll();
         push_rows(CHAR_PRINT_FIRST[CODE_W-1:0], x, y, '0);
      end else begin
         if (ch >= CHAR_PRINT_FIRST && ch <= CHAR_PRINT_LAST)
            push_rows(ch[CODE_W-1:0], x, y, color);
         x += GLYPH_WIDTH;
         if (keep_on_screen(x, y)) push_scroll();
      end
      // cursor kept modulo 4096
      cur_x = x[CURSOR_W-1:0];
      cur_y = y[CURSOR_W-1:0];
      if (pending_cmds.size() > n0) begin
         c = pending_cmds[pending_cmds.size() - 1];
         c.last = 1'b1;
         pending_cmds[pending_cmds.size() - 1] = c;
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // ------------------------------------------------------------- scoreboard
   // Everything sampled at the rising edge: register writes and accepted
   // characters feed the tracker, accepted commands pop the oldest expectation.
   always @(posedge clock) begin : scoreboard
      int n_before;
      console_cmd_type got;
      console_cmd_type want;
      if (reset) begin
         scr_w   = RST_SCREEN_WIDTH;
         scr_h   = RST_SCREEN_HEIGHT;
         pitch_b = RST_LINE_PITCH;
         pix_b   = RST_PIXEL_BYTES;
         cur_x   = CURSOR_W'(MARGIN_PIXELS);
         cur_y   = CURSOR_W'(MARGIN_PIXELS);
         pending_cmds.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  scr_w   = csr_wdata[SIZE_W-1:0];
               CSR_SCREEN_HEIGHT: scr_h   = csr_wdata[SIZE_W-1:0];
               CSR_LINE_PITCH:    pitch_b = csr_wdata[PITCH_W-1:0];
               CSR_PIXEL_BYTES:   pix_b   = csr_wdata[PIXB_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            n_before = pending_cmds.size();
            render_char(req_char_code, req_text_color);
            // a hand-typed first command replaces the computed one
            if (drv_typed && pending_cmds.size() > n_before)
               pending_cmds[n_before] = drv_first;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_kind, rsp_glyph_code, rsp_glyph_row, rsp_pixel_offset,
                    rsp_row_color, rsp_last};
            if (pending_cmds.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected command, kind %0h code %0h row %0h offset %0h",
                        $time, got.kind, got.code, got.row, got.offset);
            end else begin
               want = pending_cmds.pop_front();
               check_field("kind",         32'(want.kind),   32'(got.kind));
               check_field("glyph_code",   32'(want.code),   32'(got.code));
               check_field("glyph_row",    32'(want.row),    32'(got.row));
               check_field("pixel_offset", 32'(want.offset), 32'(got.offset));
               check_field("row_color",    32'(want.color),  32'(got.color));
               check_field("last",         32'(want.last),   32'(got.last));
            end
         end
      end
   end

   // ------------------------------------------------------- rsp back-pressure
   // Mostly short stalls, now and then a long one, and calm stretches where the
   // receiver never stalls at all.
   int stall_left = 0;
   int recv_calm  = 0;

   always @(negedge clock) begin : rsp_pressure
      int roll;
      if (stall_left > 0) begin
         stall_left--;
      end else if (recv_calm > 0) begin
         recv_calm--;
         rsp_stall <= 1'b0;
      end else begin
         roll = $urandom_range(99);
         if (roll < 2) begin
            recv_calm = $urandom_range(30, 100);
            rsp_stall <= 1'b0;
         end else if (roll < 60) begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(0, 6);
         end else if (roll < 95) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(9, 39);
         end
      end
   end

   // ---------------------------------------------------------- req side
   int send_calm = 0;

   // idle cycles before the next char: usually none, some short, a few long
   function automatic int sender_gap();
      int roll;
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
         send_calm = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [CHAR_W-1:0] random_char(input bit tall);
      int roll;
      roll = $urandom_range(99);
      if (tall) begin
         // newline heavy: walks the cursor down past the 12-bit wrap
         if (roll < 95) return CHAR_NEWLINE;
         if (roll < 98) return CHAR_W'($urandom_range(32, 126));
         return CHAR_W'($urandom_range(0, 255));
      end
      if (roll < 45) return CHAR_W'($urandom_range(32, 126));
      if (roll < 62) return CHAR_NEWLINE;
      if (roll < 77) return CHAR_BACKSPACE;
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [COLOR_W-1:0] random_color();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return COLOR_W'($urandom);
   endfunction

   // Present one char at the falling edge and hold it until the transfer.
   // Returns at the falling edge after the transfer with valid still high.
   task automatic send_char(input logic [CHAR_W-1:0] code,
                            input logic [COLOR_W-1:0] color,
                            input logic typed, input console_cmd_type first);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_char_code  <= code;
      req_text_color <= color;
      drv_typed      <= typed;
      drv_first      <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop sending and wait until every expected command has come out;
   // with settle, also let any char that makes no command drain through.
   task automatic wait_idle(input bit settle);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_cmds.size() != 0);
      if (settle) repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] w,
                               input logic [CSR_DATA_W-1:0] h,
                               input logic [CSR_DATA_W-1:0] pitch,
                               input logic [CSR_DATA_W-1:0] bytes);
      wait_idle(1'b1);
      write_reg(CSR_SCREEN_WIDTH, w);
      write_reg(CSR_SCREEN_HEIGHT, h);
      write_reg(CSR_LINE_PITCH, pitch);
      write_reg(CSR_PIXEL_BYTES, bytes);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------- opening script
   // After reset: 1024x768, pitch 3072, 3 bytes per pixel, cursor at (4,4).
   script_step_type script_tbl [SCRIPT_LEN] = '{
      // 'A' at the home cell: row 0 starts at 4*3072 + 4*3
      '{STEP_CHAR, '0, 8'd65, 24'hFFFFFF, 1'b1,
        '{KIND_GLYPH_ROW, 7'd65, 4'd0, 26'd12300, 24'hFFFFFF, 1'b0}},
      // backspace back onto the home cell, blank drawn in black
      '{STEP_CHAR, '0, CHAR_BACKSPACE, 24'h000000, 1'b1,
        '{KIND_GLYPH_ROW, 7'd32, 4'd0, 26'd12300, 24'h000000, 1'b0}},
      // backspace at line start: last cell x=1012 of the line above, clamped
      // to the top margin
      '{STEP_CHAR, '0, CHAR_BACKSPACE, 24'h123456, 1'b1,
        '{KIND_GLYPH_ROW, 7'd32, 4'd0, 26'd15324, 24'h000000, 1'b0}},
      '{STEP_CHAR, '0, 8'd122, 24'hAAAAAA, 1'b0, NO_CMD},  // last cell, wraps
      '{STEP_CHAR, '0, 8'd126, 24'h555555, 1'b0, NO_CMD},
      '{STEP_CHAR, '0, 8'd32,  24'hFFFFFF, 1'b0, NO_CMD},
      '{STEP_CHAR, '0, 8'd0,   24'h000000, 1'b0, NO_CMD},  // advance only
      '{STEP_CHAR, '0, 8'd31,  24'hFFFFFF, 1'b0, NO_CMD},
      '{STEP_CHAR, '0, 8'd127, 24'hAAAAAA, 1'b0, NO_CMD},
      '{STEP_CHAR, '0, 8'd255, 24'h555555, 1'b0, NO_CMD},
      '{STEP_CHAR, '0, 8'd170, 24'h000000, 1'b0, NO_CMD},
      '{STEP_CHAR, '0, 8'd85,  24'hFFFFFF, 1'b0, NO_CMD},
      '{STEP_CHAR, '0, CHAR_NEWLINE, 24'h000000, 1'b0, NO_CMD},
      // tiny screen (scroll target above margin), widest fields
      '{STEP_REG, CSR_SCREEN_HEIGHT, '0, 24'd40,    1'b0, NO_CMD},
      '{STEP_REG, CSR_SCREEN_WIDTH,  '0, 24'd8191,  1'b0, NO_CMD},
      '{STEP_REG, CSR_LINE_PITCH,    '0, 24'd32767, 1'b0, NO_CMD},
      '{STEP_REG, CSR_PIXEL_BYTES,   '0, 24'd7,     1'b0, NO_CMD},
      '{STEP_CHAR, '0, CHAR_NEWLINE, 24'hFFFFFF, 1'b0, NO_CMD},
      '{STEP_CHAR, '0, CHAR_NEWLINE, 24'h000000, 1'b0, NO_CMD},
      '{STEP_CHAR, '0, 8'd72,  24'h0F0F0F, 1'b0, NO_CMD},
      '{STEP_CHAR, '0, CHAR_BACKSPACE, 24'hFFFFFF, 1'b0, NO_CMD},
      // back to last cell x=8172, which the cursor keeps as 4076
      '{STEP_CHAR, '0, CHAR_BACKSPACE, 24'h000000, 1'b0, NO_CMD},
      '{STEP_CHAR, '0, 8'd81,  24'hF0F0F0, 1'b0, NO_CMD},
      '{STEP_CHAR, '0, 8'd82,  24'hFFFFFF, 1'b0, NO_CMD},
      '{STEP_CHAR, '0, 8'd83,  24'h000000, 1'b0, NO_CMD},  // cursor wraps past 4095
      '{STEP_CHAR, '0, 8'd84,  24'hABCDEF, 1'b0, NO_CMD}
   };

   // ---------------------------------------------------------- main sequence
   initial begin : stimulus
      int count;
      logic [CSR_DATA_W-1:0] w;
      logic [CSR_DATA_W-1:0] h;
      logic [CSR_DATA_W-1:0] p;
      logic [CSR_DATA_W-1:0] b;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script_tbl[i]) begin
         if (script_tbl[i].kind == STEP_REG) begin
            wait_idle(1'b1);
            write_reg(script_tbl[i].index, script_tbl[i].value[CSR_DATA_W-1:0]);
            csr_we <= 1'b0;
         end else begin
            send_char(script_tbl[i].code, script_tbl[i].value,
                      script_tbl[i].typed, script_tbl[i].first);
         end
      end

      // Random phases, one screen setup each; registers only change while
      // the block is idle.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin  // back to reset geometry
               w = CSR_DATA_W'(RST_SCREEN_WIDTH);  h = CSR_DATA_W'(RST_SCREEN_HEIGHT);
               p = CSR_DATA_W'(RST_LINE_PITCH);    b = CSR_DATA_W'(RST_PIXEL_BYTES);
            end
            1: begin  // low ends
               w = CSR_DATA_W'(16);  h = CSR_DATA_W'(56);
               p = CSR_DATA_W'(16);  b = CSR_DATA_W'(1);
            end
            2: begin  // high ends
               w = CSR_DATA_W'(4096);   h = CSR_DATA_W'(4096);
               p = CSR_DATA_W'(16384);  b = CSR_DATA_W'(4);
            end
            3: begin  // wrap+scroll each char
               w = '0;  h = '0;  p = '0;  b = '0;
            end
            4: begin
               w = CSR_DATA_W'(40);   h = CSR_DATA_W'(60);
               p = CSR_DATA_W'(200);  b = CSR_DATA_W'(2);
            end
            5: begin
               w = CSR_DATA_W'($urandom_range(16, 300));
               h = CSR_DATA_W'($urandom_range(56, 300));
               p = CSR_DATA_W'($urandom_range(16, 16384));
               b = CSR_DATA_W'($urandom_range(1, 4));
            end
            6: begin  // full write data, register keeps its low bits
               w = CSR_DATA_W'($urandom);
               h = CSR_DATA_W'($urandom);
               p = CSR_DATA_W'($urandom);
               b = CSR_DATA_W'($urandom);
            end
            default: begin  // tall: offsets pass 2^26, line wraps past 4095
               w = CSR_DATA_W'(8191);   h = CSR_DATA_W'(8191);
               p = CSR_DATA_W'(32767);  b = CSR_DATA_W'(7);
            end
         endcase
         program_regs(w, h, p, b);
         count = (ph == TALL_PHASE) ? TALL_ITEMS : PHASE_ITEMS;
         for (int i = 0; i < count; i++) begin
            // mid-phase hold-off: let the block drain completely
            if (i == count / 2) wait_idle(1'b0);
            send_char(random_char(ph == TALL_PHASE), random_color(), 1'b0, NO_CMD);
         end
      end

      wait_idle(1'b1);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #(40_000_000);
      $display("%0t: timeout, %0d commands still expected", $time, pending_cmds.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
